### design/md5md_pkg.sv
// Shared types, constants and round tables of the MD5 digest block.
// Used by md5md_round and md5_message_digest_top; depends on nothing.
package md5md_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam int unsigned WordsPerBlock = 16;
  localparam int unsigned LenPos        = 56;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } work_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_P80   = 6'b000010,
    S_PZERO = 6'b000100,
    S_PLEN  = 6'b001000,
    S_COMP  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  // Additive constants, floor(abs(sin(i + 1)) * 2^32).
  function automatic logic [31:0] k_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423f9;  6'd51: k = 32'hfc93ab39;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Rotation amount of a round: four amounts per group of sixteen rounds.
  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by a round.
  function automatic logic [3:0] msg_idx(input logic [5:0] r);
    logic [3:0] j;
    logic [3:0] g;
    j = r[3:0];
    case (r[5:4])
      2'd0:    g = j;
      2'd1:    g = j * 4'd5 + 4'd1;
      2'd2:    g = j * 4'd3 + 4'd5;
      2'd3:    g = j * 4'd7;
      default: g = j;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v} << s;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

### design/md5md_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package.
module md5md_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/md5md_round.sv
// One MD5 round step: round function, rotation and working-word shuffle.
// Depends on md5md_pkg.
module md5md_round (
  input  md5md_pkg::work_t w,
  input  logic [5:0]       rnd,
  input  logic [31:0]      m,
  input  logic [31:0]      ak,
  output md5md_pkg::work_t w_nxt
);
  import md5md_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (w.b & w.c) | (~w.b & w.d);
      2'd1:    f = (w.d & w.b) | (~w.d & w.c);
      2'd2:    f = w.b ^ w.c ^ w.d;
      2'd3:    f = w.c ^ (w.b | ~w.d);
      default: f = w.b ^ w.c ^ w.d;
    endcase
  end

  // ak already holds the incoming a word plus this round's constant.
  assign sum = ak + f + m;

  always_comb begin
    w_nxt.a = w.d;
    w_nxt.b = w.b + rotl32(sum, rot_amt(rnd));
    w_nxt.c = w.b;
    w_nxt.d = w.c;
  end

endmodule

### design/md5_message_digest_top.sv
// Top level of the MD5 digest block: byte gathering, padding sequencer and compression.
// Depends on md5md_pkg, md5md_ram and md5md_round.

// The block hashes a message fed one beat at a time. A beat carries one message
// byte in in_tdata when in_tuser is high; in_tlast ends the message, with or
// without a byte on that beat. Bytes are packed into little-endian words in a
// 16 x 32 block RAM. Each full 64-byte block is compressed one round per
// cycle, the message word read from the RAM in the cycle before its round,
// and in_tready is low during compression. After the last beat the sequencer
// writes the 0x80 marker, zero bytes up to offset 56 and the 64-bit bit count
// one byte per cycle outside compression, with an idle step at offset 56
// before the count, compressing as blocks fill. When the marker lands before
// offset 56 this needs one compression, otherwise two. The digest then sits
// in an output register: out_tdata bits 63:0 are digest bytes 0 to 7 and bits
// 127:64 bytes 8 to 15, the lower-numbered byte in the higher bits. New beats
// are accepted while a digest waits; only a second digest waits for the first
// one to be taken. The chaining words and the bit count return to their
// initial values after each digest.
module md5_message_digest_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] message_byte
  input  logic         in_tuser,   // [0] byte_present
  input  logic         in_tlast,   // is_last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // [63:0] digest_upper, [127:64] digest_lower
);
  import md5md_pkg::*;

  state_t       state_r, state_nxt;
  state_t       ret_r, ret_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [63:0]  cnt_r, cnt_nxt;
  logic [23:0]  asm_r, asm_nxt;
  work_t        chain_r, chain_nxt;
  work_t        w_r, w_nxt;
  logic [31:0]  ak_r, ak_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;

  logic         wr_en;
  logic [7:0]   wbyte;
  logic         enter_comp;
  logic         ram_we;
  logic [31:0]  ram_wdata;
  logic [3:0]   ram_raddr;
  logic [31:0]  ram_rdata;
  work_t        w_round;
  logic [5:0]   rnd_inc;

  assign rnd_inc = rnd_r + 6'd1;

  // Message word for the next round is addressed in the cycle before that round; outside
  // compression the address rests on word 0, ready for the first round.
  assign ram_raddr = (state_r == S_COMP) ? msg_idx(rnd_inc) : 4'd0;

  md5md_ram #(
    .WIDTH (32),
    .DEPTH (WordsPerBlock)
  ) u_block_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r[5:2]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  md5md_round u_round (
    .w     (w_r),
    .rnd   (rnd_r),
    .m     (ram_rdata),
    .ak    (ak_r),
    .w_nxt (w_round)
  );

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    asm_nxt       = asm_r;
    chain_nxt     = chain_r;
    w_nxt         = w_r;
    ak_nxt        = ak_r;
    rnd_nxt       = rnd_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    wr_en         = 1'b0;
    wbyte         = 8'h00;
    enter_comp    = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = {wbyte, asm_r};

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            wr_en   = 1'b1;
            wbyte   = in_tdata;
            cnt_nxt = cnt_r + 64'd8;
          end
          if (in_tuser && (pos_r == 6'd63)) begin
            enter_comp = 1'b1;
            ret_nxt    = in_tlast ? S_P80 : S_IDLE;
          end else if (in_tlast) begin
            state_nxt = S_P80;
          end
        end
      end
      S_P80: begin
        wr_en = 1'b1;
        wbyte = 8'h80;
        if (pos_r == 6'd63) begin
          enter_comp = 1'b1;
          ret_nxt    = S_PZERO;
        end else begin
          state_nxt = S_PZERO;
        end
      end
      S_PZERO: begin
        if (pos_r == 6'(LenPos)) begin
          state_nxt = S_PLEN;
        end else begin
          wr_en = 1'b1;
          if (pos_r == 6'd63) begin
            enter_comp = 1'b1;
            ret_nxt    = S_PZERO;
          end
        end
      end
      S_PLEN: begin
        // The count is little-endian: offset 56 takes its lowest byte.
        wr_en = 1'b1;
        wbyte = cnt_r[{pos_r[2:0], 3'b000} +: 8];
        if (pos_r == 6'd63) begin
          enter_comp = 1'b1;
          ret_nxt    = S_OUT;
        end
      end
      S_COMP: begin
        w_nxt   = w_round;
        ak_nxt  = w_r.d + k_const(rnd_inc);
        rnd_nxt = rnd_inc;
        if (rnd_r == 6'd63) begin
          chain_nxt.a = chain_r.a + w_round.a;
          chain_nxt.b = chain_r.b + w_round.b;
          chain_nxt.c = chain_r.c + w_round.c;
          chain_nxt.d = chain_r.d + w_round.d;
          state_nxt   = ret_r;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {bswap32(chain_r.c), bswap32(chain_r.d),
                           bswap32(chain_r.a), bswap32(chain_r.b)};
          chain_nxt     = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
          cnt_nxt       = 64'd0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Byte write: the first three bytes of a word collect in asm_r, the
    // fourth writes the whole word to the block RAM.
    ram_wdata = {wbyte, asm_r};
    if (wr_en) begin
      pos_nxt = pos_r + 6'd1;
      case (pos_r[1:0])
        2'd0:    asm_nxt[7:0]   = wbyte;
        2'd1:    asm_nxt[15:8]  = wbyte;
        2'd2:    asm_nxt[23:16] = wbyte;
        2'd3:    ram_we         = 1'b1;
        default: ram_we         = 1'b0;
      endcase
    end

    // The last word of a block lands in the RAM at this edge; word 0 is
    // already being read, so the first round finds its data on time.
    if (enter_comp) begin
      state_nxt = S_COMP;
      w_nxt     = chain_r;
      ak_nxt    = chain_r.a + k_const(6'd0);
      rnd_nxt   = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      pos_r       <= 6'd0;
      cnt_r       <= 64'd0;
      chain_r     <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
      rnd_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      chain_r     <= chain_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asm_r      <= asm_nxt;
    w_r        <= w_nxt;
    ak_r       <= ak_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
